FILE: rtl/wec_pkg.sv
// Shared constants and codes for the wheel encoder counter.
package wec_pkg;

   localparam int TIME_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int DIR_W       = 2;
   localparam int CMD_W       = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int DIV_W       = 42;
   localparam int SCALE_W     = 10;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 72;

   localparam int HISTORY_DEPTH_DEFAULT = 5;

   // history average by reciprocal: quotient = (sum * recip) >> AVG_SHIFT
   localparam int AVG_SHIFT  = 40;
   localparam int RECIP_W    = 41;
   localparam int RECIP_LO_W = 21;

   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERVAL = 1'b1;

   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RESET = 16'd500;
   localparam logic [CSR_DATA_W-1:0] INTERVAL_RESET = 16'd100;

   localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
   localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
   localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

   localparam logic [SCALE_W-1:0] SPEED_SCALE = 10'd1000;

   localparam logic [COUNT_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
   localparam logic [COUNT_W-1:0] SPEED_MIN = 32'h8000_0000;

endpackage

FILE: rtl/wec_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module wec_div #(
   parameter int DIVIDEND_W = wec_pkg::DIV_W,
   parameter int DIVISOR_W  = wec_pkg::TIME_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIVIDEND_W);
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a run");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0)
      else $error("divider busy with zero count");

endmodule

FILE: rtl/wheel_encoder_count_and_speed.sv
// Top level: wheel encoder counter with debounce and averaged speed.
//
// Input items arrive on req_ (command in req_tuser, pin levels and the
// microsecond and millisecond timestamps in req_tdata). Every item gives one
// result item on rsp_: edge count, last direction and speed average.
// Registers debounce_us (index 0) and interval_ms (index 1) are written on
// the csr_ port with csr_we; write them only while the block is idle.
// Sequence: an edge, clear or query that takes no sample goes through the
// EXEC and EMIT states into the result register, then back to idle. A query
// that takes a sample adds a multiply by 1000, a 42-step division on the
// one-bit-per-cycle divider, then the history average by a two-step
// reciprocal multiply.
// The block takes one item at a time; req_tready is high only in idle.
// A result waits in the output register while rsp_tready is low; the next
// item is accepted meanwhile but its result is held until the slot frees.
// Reset is synchronous: count, direction, timestamps, history and average
// go to zero, debounce_us to 500 and interval_ms to 100.
module wheel_encoder_count_and_speed #(
   parameter int HISTORY_DEPTH = wec_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // level_a, level_b, time_us, time_ms
   input  logic [wec_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  logic [wec_pkg::CMD_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // count, dir, speed_avg
   output logic [wec_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [wec_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wec_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW    = wec_pkg::COUNT_W;
   localparam int TW    = wec_pkg::TIME_W;
   localparam int DW    = wec_pkg::DIV_W;
   localparam int SUM_W = CW + $clog2(HISTORY_DEPTH) + 1;
   localparam int RW    = wec_pkg::RECIP_W;
   localparam int RLW   = wec_pkg::RECIP_LO_W;
   localparam int MUL_W = SUM_W + RLW;
   localparam int ACC_W = SUM_W + RW;

   localparam logic [63:0] AVG_RECIP =
      ((64'd1 << wec_pkg::AVG_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
   localparam logic [RLW-1:0] RECIP_LO = RLW'(AVG_RECIP);
   localparam logic [RLW-1:0] RECIP_HI = RLW'(AVG_RECIP >> RLW);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EXEC  = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_SGO   = 4'd3;
   localparam logic [3:0] ST_SWAIT = 4'd4;
   localparam logic [3:0] ST_SAT   = 4'd5;
   localparam logic [3:0] ST_AMAG  = 4'd6;
   localparam logic [3:0] ST_ALO   = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;
   localparam logic [3:0] ST_AHI   = 4'd9;
   localparam logic [3:0] ST_AFIX  = 4'd10;

   logic [3:0]                   state_ff;
   logic [wec_pkg::CSR_DATA_W-1:0] debounce_ff, interval_ff;
   logic [wec_pkg::CMD_W-1:0]    cmd_ff;
   logic                         lvl_a_ff, lvl_b_ff;
   logic [TW-1:0]                t_us_ff, t_ms_ff;
   logic [CW-1:0]                edge_count_ff;
   logic [wec_pkg::DIR_W-1:0]    last_dir_ff;
   logic [TW-1:0]                last_edge_ff, last_sample_ff;
   logic [CW-1:0]                count_at_sample_ff;
   logic [TW-1:0]                elapsed_ff;
   logic [CW-1:0]                delta_ff;
   logic                         neg_ff;
   logic [DW-1:0]                prod_ff;
   logic signed [CW-1:0]         hist_ff [HISTORY_DEPTH];
   logic [SUM_W-1:0]             sum_ff;
   logic [SUM_W-1:0]             avg_mag_ff;
   logic [ACC_W-1:0]             acc_ff;
   logic [CW-1:0]                avg_ff;
   logic                         rsp_valid_ff;
   logic [wec_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                         req_accept;
   logic [TW-1:0]                elapsed_us, elapsed_ms;
   logic [CW-1:0]                delta_mag;
   logic [CW-1:0]                sample;
   logic [CW-1:0]                quo_low;
   logic [SUM_W-1:0]             sum_mag;
   logic [SUM_W-1:0]             sum_next;
   logic [RLW-1:0]               mul_k;
   logic [MUL_W-1:0]             mul_out;
   logic [CW-1:0]                avg_quo;
   logic                         emit_ok;
   logic                         div_start;
   logic                         div_done;
   logic [DW-1:0]                div_quotient;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign emit_ok    = !rsp_valid_ff || rsp_tready;

   assign elapsed_us = t_us_ff - last_edge_ff;
   assign elapsed_ms = t_ms_ff - last_sample_ff;
   assign delta_mag  = delta_ff[CW-1] ? (~delta_ff + CW'(1)) : delta_ff;
   assign sum_mag    = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
   assign quo_low    = div_quotient[CW-1:0];

   always_comb begin
      if (!neg_ff) begin
         sample = (div_quotient > DW'(wec_pkg::SPEED_MAX)) ? wec_pkg::SPEED_MAX : quo_low;
      end else begin
         sample = (div_quotient > DW'(wec_pkg::SPEED_MIN)) ? wec_pkg::SPEED_MIN
                                                           : (~quo_low + CW'(1));
      end
   end

   assign sum_next = sum_ff
                   - {{(SUM_W-CW){hist_ff[HISTORY_DEPTH-1][CW-1]}}, hist_ff[HISTORY_DEPTH-1]}
                   + {{(SUM_W-CW){sample[CW-1]}}, sample};

   assign mul_k   = (state_ff == ST_ALO) ? RECIP_LO : RECIP_HI;
   assign mul_out = {{RLW{1'b0}}, avg_mag_ff} * {{SUM_W{1'b0}}, mul_k};
   assign avg_quo = acc_ff[wec_pkg::AVG_SHIFT +: CW];

   assign div_start = (state_ff == ST_SGO);

   wec_div #(
      .DIVIDEND_W (DW),
      .DIVISOR_W  (TW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= wec_pkg::DEBOUNCE_RESET;
         interval_ff <= wec_pkg::INTERVAL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            wec_pkg::REG_DEBOUNCE: debounce_ff <= csr_wdata;
            wec_pkg::REG_INTERVAL: interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_tuser;
         lvl_a_ff <= req_tdata[0];
         lvl_b_ff <= req_tdata[1];
         t_us_ff  <= req_tdata[33:2];
         t_ms_ff  <= req_tdata[65:34];
      end
   end

   // sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         edge_count_ff      <= '0;
         last_dir_ff        <= wec_pkg::DIR_NONE;
         last_edge_ff       <= '0;
         last_sample_ff     <= '0;
         count_at_sample_ff <= '0;
         sum_ff             <= '0;
         avg_ff             <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff <= ST_EMIT;
               case (cmd_ff)
                  wec_pkg::CMD_EDGE: begin
                     if (elapsed_us >= TW'(debounce_ff)) begin
                        if (lvl_a_ff != lvl_b_ff) begin
                           edge_count_ff <= edge_count_ff + CW'(1);
                           last_dir_ff   <= wec_pkg::DIR_UP;
                        end else begin
                           edge_count_ff <= edge_count_ff - CW'(1);
                           last_dir_ff   <= wec_pkg::DIR_DOWN;
                        end
                        last_edge_ff <= t_us_ff;
                     end
                  end
                  wec_pkg::CMD_QUERY: begin
                     if (elapsed_ms > TW'(interval_ff)) begin
                        elapsed_ff         <= elapsed_ms;
                        delta_ff           <= edge_count_ff - count_at_sample_ff;
                        count_at_sample_ff <= edge_count_ff;
                        last_sample_ff     <= t_ms_ff;
                        state_ff           <= ST_MUL;
                     end
                  end
                  wec_pkg::CMD_CLEAR: begin
                     edge_count_ff <= '0;
                  end
                  default: ;
               endcase
            end
            ST_MUL: begin
               neg_ff   <= delta_ff[CW-1];
               prod_ff  <= DW'(delta_mag) * DW'(wec_pkg::SPEED_SCALE);
               state_ff <= ST_SGO;
            end
            ST_SGO: begin
               state_ff <= ST_SWAIT;
            end
            ST_SWAIT: begin
               if (div_done) begin
                  state_ff <= ST_SAT;
               end
            end
            ST_SAT: begin
               hist_ff[0] <= sample;
               for (int i = 1; i < HISTORY_DEPTH; i++) begin
                  hist_ff[i] <= hist_ff[i-1];
               end
               sum_ff   <= sum_next;
               state_ff <= ST_AMAG;
            end
            ST_AMAG: begin
               avg_mag_ff <= sum_mag;
               state_ff   <= ST_ALO;
            end
            ST_ALO: begin
               acc_ff   <= ACC_W'(mul_out);
               state_ff <= ST_AHI;
            end
            ST_AHI: begin
               acc_ff   <= acc_ff + (ACC_W'(mul_out) << RLW);
               state_ff <= ST_AFIX;
            end
            ST_AFIX: begin
               avg_ff   <= sum_ff[SUM_W-1] ? (~avg_quo + CW'(1)) : avg_quo;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_ok) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && emit_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_EMIT && emit_ok) begin
         rsp_data_ff <= {{(wec_pkg::RSP_DATA_W - 2*CW - wec_pkg::DIR_W){1'b0}},
                         avg_ff, last_dir_ff, edge_count_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_SWAIT))
      else $error("divider result with no waiting step");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && emit_ok |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not loaded on emit");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      last_dir_ff != 2'b10)
      else $error("direction holds an unused code");

endmodule
